// ===== hw/rtl/gnms_pkg.sv =====
// Shared types and constants for the gradient non-maximum suppression block.
package gnms_pkg;

    localparam int FW_BITS  = 12;
    localparam int FH_BITS  = 13;
    localparam int ROW_W    = 14;
    localparam int DIR_BITS = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_HORIZ = 2'd0,
        DIR_DIAG  = 2'd1,
        DIR_VERT  = 2'd2,
        DIR_ANTI  = 2'd3
    } dir_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic left;
        logic right;
        logic up;
        logic down;
    } pix_ctl_t;

endpackage

// ===== hw/rtl/gnms_regs.sv =====
// Configuration registers behind the APB port, with effective frame size and pixel count.
module gnms_regs #(
    parameter int MAX_WIDTH = 2048,
    parameter int WW = 12,
    parameter int TW = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gnms_pkg::PADDR_W-1:0]     paddr,
    input  logic [gnms_pkg::PDATA_W-1:0]     pwdata,
    output logic [gnms_pkg::PDATA_W-1:0]     prdata,
    output logic                             cfg_wr,
    output logic [WW-1:0]                    eff_w,
    output logic [gnms_pkg::FH_BITS-1:0]     eff_h,
    output logic [TW-1:0]                    total
);

    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

    logic [gnms_pkg::FW_BITS-1:0] frame_width_reg;
    logic [gnms_pkg::FW_BITS-1:0] frame_width_next;
    logic [gnms_pkg::FH_BITS-1:0] frame_height_reg;
    logic [gnms_pkg::FH_BITS-1:0] frame_height_next;
    logic [WW-1:0]                width_ext;
    gnms_pkg::reg_idx_t           idx;

    assign idx    = gnms_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr)
        begin
            case (idx)
                gnms_pkg::REG_FRAME_WIDTH:
                    frame_width_next = pwdata[gnms_pkg::FW_BITS-1:0];
                gnms_pkg::REG_FRAME_HEIGHT:
                    frame_height_next = pwdata[gnms_pkg::FH_BITS-1:0];
                default:
                    frame_width_next = frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            gnms_pkg::REG_FRAME_WIDTH:
                prdata = gnms_pkg::PDATA_W'(frame_width_reg);
            gnms_pkg::REG_FRAME_HEIGHT:
                prdata = gnms_pkg::PDATA_W'(frame_height_reg);
            default:
                prdata = '0;
        endcase
    end

    always_comb
    begin
        width_ext = WW'(frame_width_reg);
        if (width_ext == '0)
        begin
            eff_w = WW'(1);
        end
        else if (width_ext > MAXW)
        begin
            eff_w = MAXW;
        end
        else
        begin
            eff_w = width_ext;
        end
        eff_h = (frame_height_reg == '0) ? gnms_pkg::FH_BITS'(1) : frame_height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gnms_pkg::FW_BITS'(2048);
            frame_height_reg <= gnms_pkg::FH_BITS'(1);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign total = TW'(eff_w) * TW'(eff_h);

endmodule

// ===== hw/rtl/gnms_line_buffer.sv =====
// Two row memories (center row with direction, upper row) with write-to-read forwarding.
module gnms_line_buffer #(
    parameter int DEPTH = 2048,
    parameter int MAG_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [MAG_BITS+gnms_pkg::DIR_BITS-1:0] wr_center,
    input  logic [MAG_BITS-1:0]                 wr_upper,
    output logic [MAG_BITS+gnms_pkg::DIR_BITS-1:0] rd_center,
    output logic [MAG_BITS-1:0]                 rd_upper
);

    localparam int CW = MAG_BITS + gnms_pkg::DIR_BITS;

    logic [CW-1:0]       center_mem [DEPTH];
    logic [MAG_BITS-1:0] upper_mem [DEPTH];

    logic [CW-1:0]       center_rd_reg;
    logic [MAG_BITS-1:0] upper_rd_reg;
    logic                fwd_hit_reg;
    logic [CW-1:0]       fwd_center_reg;
    logic [MAG_BITS-1:0] fwd_upper_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_mem[wr_addr] <= wr_center;
            upper_mem[wr_addr]  <= wr_upper;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            center_rd_reg <= center_mem[rd_addr];
            upper_rd_reg  <= upper_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_hit_reg    <= wr_en && (wr_addr == rd_addr);
            fwd_center_reg <= wr_center;
            fwd_upper_reg  <= wr_upper;
        end
    end

    assign rd_center = fwd_hit_reg ? fwd_center_reg : center_rd_reg;
    assign rd_upper  = fwd_hit_reg ? fwd_upper_reg : upper_rd_reg;

endmodule

// ===== hw/rtl/gnms_window.sv =====
// Two-column window, neighbor comparison and output word register.
module gnms_window #(
    parameter int MAG_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    clear,
    input  gnms_pkg::pix_ctl_t      ctl,
    input  logic [MAG_BITS-1:0]     lower_mag,
    input  logic [MAG_BITS-1:0]     center_mag,
    input  gnms_pkg::dir_t          center_dir,
    input  logic [MAG_BITS-1:0]     upper_mag,
    output logic                    stage_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MAG_BITS-1:0]     suppressed_value,
    output logic                    frame_end
);

    logic [MAG_BITS-1:0] w1_upper_reg;
    logic [MAG_BITS-1:0] w1_center_reg;
    logic [MAG_BITS-1:0] w1_lower_reg;
    logic [MAG_BITS-1:0] w2_upper_reg;
    logic [MAG_BITS-1:0] w2_center_reg;
    gnms_pkg::dir_t      w2_dir_reg;
    logic [MAG_BITS-1:0] w2_lower_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [MAG_BITS-1:0] value_reg;
    logic                frame_end_reg;

    logic [MAG_BITS-1:0] cmp_a;
    logic [MAG_BITS-1:0] cmp_b;
    logic                in_frame;
    logic [MAG_BITS-1:0] result;

    always_comb
    begin
        case (w2_dir_reg)
            gnms_pkg::DIR_HORIZ:
            begin
                cmp_a    = w1_center_reg;
                cmp_b    = center_mag;
                in_frame = ctl.left && ctl.right;
            end
            gnms_pkg::DIR_VERT:
            begin
                cmp_a    = w2_upper_reg;
                cmp_b    = w2_lower_reg;
                in_frame = ctl.up && ctl.down;
            end
            gnms_pkg::DIR_DIAG:
            begin
                cmp_a    = w1_upper_reg;
                cmp_b    = lower_mag;
                in_frame = ctl.left && ctl.right && ctl.up && ctl.down;
            end
            default:
            begin
                cmp_a    = w1_lower_reg;
                cmp_b    = upper_mag;
                in_frame = ctl.left && ctl.right && ctl.up && ctl.down;
            end
        endcase
        if (in_frame && ((w2_center_reg < cmp_a) || (w2_center_reg < cmp_b)))
        begin
            result = '0;
        end
        else
        begin
            result = w2_center_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_upper_reg  <= '0;
            w1_center_reg <= '0;
            w1_lower_reg  <= '0;
            w2_upper_reg  <= '0;
            w2_center_reg <= '0;
            w2_dir_reg    <= gnms_pkg::DIR_HORIZ;
            w2_lower_reg  <= '0;
        end
        else if (clear || (adv && ctl.last))
        begin
            w1_upper_reg  <= '0;
            w1_center_reg <= '0;
            w1_lower_reg  <= '0;
            w2_upper_reg  <= '0;
            w2_center_reg <= '0;
            w2_dir_reg    <= gnms_pkg::DIR_HORIZ;
            w2_lower_reg  <= '0;
        end
        else if (adv)
        begin
            w1_upper_reg  <= w2_upper_reg;
            w1_center_reg <= w2_center_reg;
            w1_lower_reg  <= w2_lower_reg;
            w2_upper_reg  <= upper_mag;
            w2_center_reg <= center_mag;
            w2_dir_reg    <= center_dir;
            w2_lower_reg  <= lower_mag;
        end
    end

    assign stage_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv && ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl.emit)
        begin
            value_reg     <= result;
            frame_end_reg <= ctl.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign suppressed_value = value_reg;
    assign frame_end        = frame_end_reg;

endmodule

// ===== hw/rtl/gradient_nonmax_suppression.sv =====
// Top level of the gradient non-maximum suppression block: stream position and pipeline control.
//
//   Channel   Signals                                        Direction
//   config    psel penable pwrite paddr pwdata prdata pready  APB slave
//   input     in_valid in_ready magnitude direction flush    word in
//   output    out_valid out_ready suppressed_value frame_end word out
//
// One word is accepted per clock unless the output stalls; the line buffer read issues at
// acceptance and the read-modify-write back to the same column completes when stage 1 advances,
// when the result enters the output register, so a result word trails its pixel by one row
// and one pixel of stream. Reset clears the stream position, the window and out_valid; the
// row memories and the output word are not cleared. While the output word is not taken,
// a word to be emitted holds in stage 1, so the pipeline holds and in_ready drops.
module gradient_nonmax_suppression #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAG_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gnms_pkg::PADDR_W-1:0]     paddr,
    input  logic [gnms_pkg::PDATA_W-1:0]     pwdata,
    output logic [gnms_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [MAG_BITS-1:0]              magnitude,
    input  logic [gnms_pkg::DIR_BITS-1:0]    direction,
    input  logic                             flush,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [MAG_BITS-1:0]              suppressed_value,
    output logic                             frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int WW = (WB > gnms_pkg::FW_BITS) ? WB : gnms_pkg::FW_BITS;
    localparam int TW = WW + gnms_pkg::FH_BITS;
    localparam int RW = gnms_pkg::ROW_W;
    localparam int CW = MAG_BITS + gnms_pkg::DIR_BITS;

    logic                         cfg_wr;
    logic [WW-1:0]                eff_w;
    logic [gnms_pkg::FH_BITS-1:0] eff_h;
    logic [TW-1:0]                total;

    logic [AW-1:0] in_col_reg;
    logic [AW-1:0] in_col_next;
    logic [RW-1:0] in_row_reg;
    logic [RW-1:0] in_row_next;
    logic [TW-1:0] out_idx_reg;
    logic [TW-1:0] out_idx_next;

    logic               accept;
    logic               col_nz;
    logic [WW-1:0]      col_plus;
    logic               wrap;
    logic [RW-1:0]      h_ext;
    gnms_pkg::pix_ctl_t ctl;
    logic [MAG_BITS-1:0] in_mag;
    gnms_pkg::dir_t      in_dir;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    gnms_pkg::pix_ctl_t  s1_ctl_reg;
    logic [AW-1:0]       s1_col_reg;
    logic [MAG_BITS-1:0] s1_mag_reg;
    gnms_pkg::dir_t      s1_dir_reg;
    logic                s1_adv;
    logic                stage_ready;

    logic [CW-1:0]       rd_center;
    logic [MAG_BITS-1:0] rd_upper;

    assign pready = 1'b1;

    gnms_regs #(
        .MAX_WIDTH(MAX_WIDTH),
        .WW(WW),
        .TW(TW)
    ) u_regs (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .cfg_wr(cfg_wr),
        .eff_w(eff_w),
        .eff_h(eff_h),
        .total(total)
    );

    assign accept = in_valid && in_ready;
    assign s1_adv = s1_valid_reg && (!s1_ctl_reg.emit || stage_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign in_mag = flush ? '0 : magnitude;
    assign in_dir = flush ? gnms_pkg::DIR_HORIZ : gnms_pkg::dir_t'(direction);

    always_comb
    begin
        col_nz    = (in_col_reg != '0);
        col_plus  = WW'(in_col_reg) + WW'(1);
        wrap      = (col_plus >= eff_w);
        h_ext     = RW'(eff_h);
        ctl.emit  = col_nz ? (in_row_reg >= RW'(1)) : (in_row_reg >= RW'(2));
        ctl.left  = col_nz ? (WW'(in_col_reg) >= WW'(2)) : (eff_w >= WW'(2));
        ctl.right = col_nz;
        ctl.up    = col_nz ? (in_row_reg >= RW'(2)) : (in_row_reg >= RW'(3));
        ctl.down  = col_nz ? (in_row_reg < h_ext) : (in_row_reg <= h_ext);
        ctl.last  = ctl.emit && (({1'b0, out_idx_reg} + (TW+1)'(1)) >= {1'b0, total});
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_idx_next = out_idx_reg;
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_idx_next = '0;
        end
        else if (accept)
        begin
            if (ctl.last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_idx_next = '0;
            end
            else
            begin
                in_col_next  = wrap ? '0 : col_plus[AW-1:0];
                in_row_next  = in_row_reg + RW'(wrap);
                out_idx_next = out_idx_reg + TW'(ctl.emit);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_idx_reg  <= out_idx_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
            s1_col_reg <= in_col_reg;
            s1_mag_reg <= in_mag;
            s1_dir_reg <= in_dir;
        end
    end

    gnms_line_buffer #(
        .DEPTH(MAX_WIDTH),
        .MAG_BITS(MAG_BITS)
    ) u_line_buffer (
        .clk(clk),
        .rd_en(accept),
        .rd_addr(in_col_reg),
        .wr_en(s1_adv),
        .wr_addr(s1_col_reg),
        .wr_center({s1_mag_reg, s1_dir_reg}),
        .wr_upper(rd_center[CW-1:gnms_pkg::DIR_BITS]),
        .rd_center(rd_center),
        .rd_upper(rd_upper)
    );

    gnms_window #(
        .MAG_BITS(MAG_BITS)
    ) u_window (
        .clk(clk),
        .rst_n(rst_n),
        .adv(s1_adv),
        .clear(cfg_wr),
        .ctl(s1_ctl_reg),
        .lower_mag(s1_mag_reg),
        .center_mag(rd_center[CW-1:gnms_pkg::DIR_BITS]),
        .center_dir(gnms_pkg::dir_t'(rd_center[gnms_pkg::DIR_BITS-1:0])),
        .upper_mag(rd_upper),
        .stage_ready(stage_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .suppressed_value(suppressed_value),
        .frame_end(frame_end)
    );

endmodule

// ===== bench/gradient_nonmax_suppression_test.sv =====
// Self-checking testbench for the gradient non-maximum suppression block.
module gradient_nonmax_suppression_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 800000;
    localparam int SETTLE       = 8;
    localparam int RANDOM_WORDS = 750;
    localparam int CALM_WORDS   = 150;
    localparam int ROW_CAP      = 2048;

    class nms_scoreboard;
        typedef struct {
            bit [15:0] upper;
            bit [15:0] center;
            bit [1:0]  center_dir;
            bit [15:0] lower;
        } window_col_t;

        typedef struct {
            bit [15:0] value;
            bit        last;
        } pixel_out_t;

        bit [11:0]       width_reg  = 12'd2048;
        bit [12:0]       height_reg = 13'd1;
        bit [17:0]       center_mem [ROW_CAP];
        bit [15:0]       upper_mem [ROW_CAP];
        window_col_t     win [3];
        int              col_pos;
        int              row_pos;
        longint          out_count;
        pixel_out_t      expected_pixels [$];
        int              errors;
        int              checked;
        int              frames;

        function void restart();
            foreach (win[i]) win[i] = '{default: 0};
            col_pos = 0;
            row_pos = 0;
            out_count = 0;
        endfunction

        function int frame_w();
            if (width_reg == 0) return 1;
            if (width_reg > ROW_CAP) return ROW_CAP;
            return width_reg;
        endfunction

        function int frame_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void set_register(gnms_pkg::reg_idx_t idx, bit [31:0] value);
            case (idx)
                gnms_pkg::REG_FRAME_WIDTH:  width_reg = value[11:0];
                gnms_pkg::REG_FRAME_HEIGHT: height_reg = value[12:0];
                default: ;
            endcase
            restart();
        endfunction

        function void take_pixel(bit [15:0] mag_in, bit [1:0] dir_in, bit fl);
            int          w;
            int          h;
            int          r;
            int          c;
            int          col;
            bit [15:0]   mag;
            bit [15:0]   v;
            bit [15:0]   a;
            bit [15:0]   b;
            bit [1:0]    dir;
            bit          in_frame;
            bit          left;
            bit          right;
            bit          up;
            bit          down;
            bit          last;
            window_col_t nc;
            w = frame_w();
            h = frame_h();
            mag = fl ? 16'd0 : mag_in;
            dir = fl ? 2'd0 : dir_in;
            col = col_pos % ROW_CAP;
            nc.upper = upper_mem[col];
            nc.center = center_mem[col][17:2];
            nc.center_dir = center_mem[col][1:0];
            nc.lower = mag;
            upper_mem[col] = nc.center;
            center_mem[col] = {mag, dir};
            win[0] = win[1];
            win[1] = win[2];
            win[2] = nc;
            if (col_pos >= 1) begin
                r = row_pos - 1;
                c = col_pos - 1;
            end
            else begin
                r = row_pos - 2;
                c = w - 1;
            end
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (r < 0) return;
            v = win[1].center;
            left = c >= 1;
            right = c + 1 < w;
            up = r >= 1;
            down = r + 1 < h;
            case (gnms_pkg::dir_t'(win[1].center_dir))
                gnms_pkg::DIR_HORIZ:
                begin
                    a = win[0].center;
                    b = win[2].center;
                    in_frame = left && right;
                end
                gnms_pkg::DIR_VERT:
                begin
                    a = win[1].upper;
                    b = win[1].lower;
                    in_frame = up && down;
                end
                gnms_pkg::DIR_DIAG:
                begin
                    a = win[0].upper;
                    b = win[2].lower;
                    in_frame = left && right && up && down;
                end
                default:
                begin
                    a = win[0].lower;
                    b = win[2].upper;
                    in_frame = left && right && up && down;
                end
            endcase
            if (in_frame && (v < a || v < b)) v = 16'd0;
            last = out_count + 1 >= longint'(w) * longint'(h);
            expected_pixels.push_back('{v, last});
            out_count++;
            if (last) restart();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_pixel(logic [15:0] value, logic fe);
            pixel_out_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("word %0d frame_end %b arrived with none expected", value, fe));
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (value !== want.value)
                report($sformatf("word %0d: suppressed_value %0d, expected %0d",
                                 checked, value, want.value));
            if (fe !== want.last)
                report($sformatf("word %0d: frame_end %b, expected %b", checked, fe, want.last));
            if (want.last) frames++;
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gnms_pkg::PADDR_W-1:0]  paddr = '0;
    logic [gnms_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [gnms_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [15:0]                   magnitude = '0;
    logic [gnms_pkg::DIR_BITS-1:0] direction = '0;
    logic                          flush = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b1;
    logic [15:0]                   suppressed_value;
    logic                          frame_end;

    nms_scoreboard sb = new();
    int            cycles = 0;
    int            stall_left = 0;
    int            sent_words = 0;
    int            cur_w = 2048;
    int            cur_h = 1;
    bit            steady = 1'b0;

    gradient_nonmax_suppression DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else if (!steady && $urandom_range(0, 99) < 15) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(1, 7);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && in_valid && in_ready) sb.take_pixel(magnitude, direction, flush);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check_pixel(suppressed_value, frame_end);

    function automatic bit [15:0] pick_magnitude();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return 16'($urandom_range(0, 3));
        if (sel < 40) return (sel < 35) ? 16'd0 : 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic apb_write(gnms_pkg::reg_idx_t idx, bit [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, data);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(gnms_pkg::reg_idx_t idx, bit [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            sb.report($sformatf("register %s read %0h, expected %0h", idx.name(), prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_frame(int wv, int hv);
        bit [31:0] wd;
        bit [31:0] hd;
        wd = ($urandom & 32'hFFFF_F000) | (wv & 32'hFFF);
        hd = ($urandom & 32'hFFFF_E000) | (hv & 32'h1FFF);
        apb_write(gnms_pkg::REG_FRAME_WIDTH, wd);
        apb_write(gnms_pkg::REG_FRAME_HEIGHT, hd);
        apb_read_check(gnms_pkg::REG_FRAME_WIDTH, wd & 32'hFFF);
        apb_read_check(gnms_pkg::REG_FRAME_HEIGHT, hd & 32'h1FFF);
        cur_w = sb.frame_w();
        cur_h = sb.frame_h();
    endtask

    task automatic send_word(bit [15:0] m, bit [1:0] d, bit f);
        if (!steady && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        magnitude <= m;
        direction <= d;
        flush <= f;
        do @(posedge clk); while (!in_ready);
        sent_words++;
    endtask

    task automatic finish_words();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_frames(int count);
        repeat (count) begin
            for (int i = 0; i < cur_w * cur_h; i++)
                send_word(pick_magnitude(), 2'($urandom_range(0, 3)), $urandom_range(0, 99) < 5);
            for (int i = 0; i <= cur_w; i++)
                send_word(pick_magnitude(), 2'($urandom_range(0, 3)), $urandom_range(0, 99) < 80);
        end
    endtask

    task automatic send_loose(int count);
        repeat (count)
            send_word(pick_magnitude(), 2'($urandom_range(0, 3)), $urandom_range(0, 99) < 30);
    endtask

    task automatic run_directed();
        bit [15:0]      mags [16] = '{100, 16'hFFFF, 0, 7,
                                      50, 200, 10, 0,
                                      300, 5, 200, 16'hFFFF,
                                      0, 16'hFFFF, 1, 16'hFFFF};
        gnms_pkg::dir_t dirs [16] = '{gnms_pkg::DIR_HORIZ, gnms_pkg::DIR_DIAG,
                                      gnms_pkg::DIR_HORIZ, gnms_pkg::DIR_ANTI,
                                      gnms_pkg::DIR_VERT, gnms_pkg::DIR_HORIZ,
                                      gnms_pkg::DIR_DIAG, gnms_pkg::DIR_VERT,
                                      gnms_pkg::DIR_DIAG, gnms_pkg::DIR_VERT,
                                      gnms_pkg::DIR_ANTI, gnms_pkg::DIR_HORIZ,
                                      gnms_pkg::DIR_ANTI, gnms_pkg::DIR_VERT,
                                      gnms_pkg::DIR_DIAG, gnms_pkg::DIR_HORIZ};
        program_frame(4, 4);
        for (int i = 0; i < 16; i++) begin
            if (i == 2)
                send_word(16'hFFFF, gnms_pkg::DIR_ANTI, 1'b1);
            else
                send_word(mags[i], dirs[i], 1'b0);
        end
        for (int i = 0; i < 5; i++)
            send_word(pick_magnitude(), 2'($urandom_range(0, 3)), i >= 3);
        finish_words();
    endtask

    initial
    begin
        int base;
        int sel;
        int wv;
        int hv;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(gnms_pkg::REG_FRAME_WIDTH, 32'd2048);
        apb_read_check(gnms_pkg::REG_FRAME_HEIGHT, 32'd1);
        run_directed();

        program_frame(0, 0);
        send_frames(2);
        finish_words();
        program_frame(4095, 0);
        send_loose(20);
        finish_words();
        program_frame(2048, 1);
        send_loose(10);
        finish_words();
        program_frame(1, 4096);
        send_loose(300);
        finish_words();
        program_frame(2, 8191);
        send_loose(150);
        finish_words();

        base = sent_words;
        while (sent_words - base < RANDOM_WORDS) begin
            steady = (sent_words - base > RANDOM_WORDS - CALM_WORDS) ||
                     ($urandom_range(0, 99) < 20);
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                wv = $urandom_range(1, 8);
                hv = $urandom_range(1, 5);
            end
            else if (sel < 90) begin
                wv = $urandom_range(9, 40);
                hv = $urandom_range(1, 12);
            end
            else begin
                wv = $urandom_range(0, 3);
                hv = $urandom_range(0, 3);
            end
            program_frame(wv, hv);
            if ($urandom_range(0, 99) < 85)
                send_frames($urandom_range(1, 3));
            else
                send_loose($urandom_range(1, 3 * cur_w * cur_h + 2));
            finish_words();
        end
        steady = 1'b1;
        repeat (2 * SETTLE) @(posedge clk);

        $display("Sent %0d input words; checked %0d result words across %0d complete frames.",
                 sent_words, sb.checked, sb.frames);
        $display("Frames ranged from one pixel to clamped full-width rows and tall columns.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== gradient_nonmax_suppression.f =====
hw/rtl/gnms_pkg.sv
hw/rtl/gnms_regs.sv
hw/rtl/gnms_line_buffer.sv
hw/rtl/gnms_window.sv
hw/rtl/gradient_nonmax_suppression.sv
bench/gradient_nonmax_suppression_test.sv
